@@ rtl/core/jbec_pkg.sv @@
`default_nettype none

package jbec_pkg;

	// block geometry and coefficient format
	localparam int BLOCK_COEFS = 64;
	localparam int COEF_BITS   = 12;
	localparam int COMPONENTS  = 3;
	localparam int POS_W       = $clog2(BLOCK_COEFS);
	localparam int RUN_W       = POS_W;
	localparam int VAL_W       = COEF_BITS + 1;
	localparam int SIZE_W      = $clog2(VAL_W + 1);
	localparam int ZRL_W       = RUN_W - 4;

	// code table layout: {length, code}
	localparam int CODE_W  = 16;
	localparam int LEN_W   = 5;
	localparam int ENTRY_W = LEN_W + CODE_W;
	localparam int SYM_W   = 8;
	localparam int DC_SYMS = 16;
	localparam int DC_AW   = 5;
	localparam int AC_AW   = 9;
	localparam int DC_DEPTH = 32;
	localparam int AC_DEPTH = 512;

	// result fields
	localparam int EBITS_W = 12;
	localparam int ELEN_W  = 4;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [SYM_W-1:0] SYM_ZRL  = 8'hF0;
	localparam logic [LEN_W-1:0] LEN_MAX  = 5'd16;
	localparam int               SIZE_SAT = 15;

	// bits of the table select field
	localparam int TSEL_AC_BIT    = 0;
	localparam int TSEL_CLASS_BIT = 1;

	typedef enum logic [1:0] {
		CMD_COEF    = 2'd0,
		CMD_LOAD    = 2'd1,
		CMD_RESTART = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		JOB_DC      = 2'd0,
		JOB_AC      = 2'd1,
		JOB_LOAD_DC = 2'd2,
		JOB_LOAD_AC = 2'd3
	} job_kind_t;

	typedef struct packed {
		logic [1:0]              command;
		logic [1:0]              component;
		logic signed [COEF_BITS-1:0] coefficient;
		logic [1:0]              table_select;
		logic [SYM_W-1:0]        symbol;
		logic [LEN_W-1:0]        load_length;
		logic [CODE_W-1:0]       load_code;
	} item_t;

	typedef struct packed {
		logic [CODE_W-1:0]  huff_code;
		logic [LEN_W-1:0]   huff_length;
		logic [EBITS_W-1:0] extra_bits;
		logic [ELEN_W-1:0]  extra_length;
		logic               block_end;
		logic               last;
	} word_t;

	// one unit of work for the back end
	typedef struct packed {
		job_kind_t          kind;
		logic               cls;
		logic [SYM_W-1:0]   symbol;
		logic [ZRL_W-1:0]   zrl_cnt;
		logic [EBITS_W-1:0] extra_bits;
		logic [ELEN_W-1:0]  extra_length;
		logic               block_end;
		logic [ENTRY_W-1:0] entry;
	} job_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} q_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/jbec_front.sv @@
`default_nettype none

module jbec_front #(
	parameter int COMPONENTS = jbec_pkg::COMPONENTS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire jbec_pkg::item_t  item,
	output logic                  push,
	output jbec_pkg::job_t        push_job,
	input  wire jbec_pkg::q_stat_t q_stat
);

	localparam int CIDX_W = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;

	logic [jbec_pkg::POS_W-1:0]     position_q;
	logic [jbec_pkg::RUN_W-1:0]     zero_run_q;
	logic [jbec_pkg::COEF_BITS-1:0] pred_q [COMPONENTS];

	logic accept, in_range, is_coef, load_ok, first, final_pos, v_zero, emit;
	logic [CIDX_W-1:0] cidx;
	logic signed [jbec_pkg::VAL_W-1:0] v_ext, p_ext, value_d;

	logic                           s1_valid_q;
	jbec_pkg::job_kind_t            kind_s1;
	logic                           cls_s1;
	logic signed [jbec_pkg::VAL_W-1:0] value_s1;
	logic [3:0]                     run_s1;
	logic [jbec_pkg::ZRL_W-1:0]     zrl_s1;
	logic                           bend_s1;
	logic [jbec_pkg::SYM_W-1:0]     sym_s1;
	logic [jbec_pkg::LEN_W-1:0]     len_s1;
	logic [jbec_pkg::CODE_W-1:0]    code_s1;

	logic [jbec_pkg::VAL_W-1:0]  mag, amp;
	logic                        neg;
	logic [jbec_pkg::SIZE_W-1:0] size;
	logic [3:0]                  snib;
	logic [jbec_pkg::LEN_W-1:0]  len_sat;
	logic [jbec_pkg::CODE_W-1:0] code_m;

	// classify the incoming item
	always_comb begin
		accept    = item_valid && !item_stall;
		cidx      = item.component[CIDX_W-1:0];
		in_range  = int'(item.component) < COMPONENTS;
		is_coef   = (item.command == jbec_pkg::CMD_COEF) && in_range;
		first     = (position_q == '0);
		final_pos = (position_q == jbec_pkg::POS_W'(jbec_pkg::BLOCK_COEFS - 1));
		v_zero    = (item.coefficient == '0);
		v_ext     = {item.coefficient[jbec_pkg::COEF_BITS-1], item.coefficient};
		p_ext     = {pred_q[cidx][jbec_pkg::COEF_BITS-1], pred_q[cidx]};
		value_d   = first ? (v_ext - p_ext) : v_ext;
		load_ok   = (item.command == jbec_pkg::CMD_LOAD) &&
			(item.table_select[jbec_pkg::TSEL_AC_BIT] ||
			 (item.symbol < jbec_pkg::SYM_W'(jbec_pkg::DC_SYMS)));
		emit      = is_coef && (first || !v_zero || final_pos);
	end

	// block position, zero run and dc predictors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			zero_run_q <= '0;
			for (int i = 0; i < COMPONENTS; i++) begin
				pred_q[i] <= '0;
			end
		end else if (accept) begin
			if (item.command == jbec_pkg::CMD_RESTART) begin
				position_q <= '0;
				zero_run_q <= '0;
				for (int i = 0; i < COMPONENTS; i++) begin
					pred_q[i] <= '0;
				end
			end else if (is_coef) begin
				if (first) begin
					pred_q[cidx] <= item.coefficient;
					zero_run_q   <= '0;
					position_q   <= jbec_pkg::POS_W'(1);
				end else if (final_pos) begin
					position_q <= '0;
					zero_run_q <= '0;
				end else begin
					position_q <= position_q + 1'b1;
					zero_run_q <= v_zero ? (zero_run_q + 1'b1) : '0;
				end
			end
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept && (emit || load_ok)) begin
			s1_valid_q <= 1'b1;
		end else if (push) begin
			s1_valid_q <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept && (emit || load_ok)) begin
			if (load_ok) begin
				kind_s1 <= item.table_select[jbec_pkg::TSEL_AC_BIT] ?
					jbec_pkg::JOB_LOAD_AC : jbec_pkg::JOB_LOAD_DC;
				cls_s1  <= item.table_select[jbec_pkg::TSEL_CLASS_BIT];
			end else begin
				kind_s1 <= first ? jbec_pkg::JOB_DC : jbec_pkg::JOB_AC;
				cls_s1  <= (item.component != '0);
			end
			value_s1 <= value_d;
			run_s1   <= (first || v_zero) ? 4'd0 : zero_run_q[3:0];
			zrl_s1   <= (first || v_zero) ? '0 : zero_run_q[jbec_pkg::RUN_W-1:4];
			bend_s1  <= !first && final_pos;
			sym_s1   <= item.symbol;
			len_s1   <= item.load_length;
			code_s1  <= item.load_code;
		end
	end

	// amplitude size and bits, code entry for loads
	always_comb begin
		neg  = value_s1[jbec_pkg::VAL_W-1];
		mag  = neg ? jbec_pkg::VAL_W'(-value_s1) : jbec_pkg::VAL_W'(value_s1);
		size = '0;
		for (int i = 0; i < jbec_pkg::VAL_W; i++) begin
			if (mag[i]) begin
				size = jbec_pkg::SIZE_W'(i + 1);
			end
		end
		for (int i = 0; i < jbec_pkg::VAL_W; i++) begin
			amp[i] = (i < int'(size)) ? (mag[i] ^ neg) : 1'b0;
		end
		snib = (int'(size) > jbec_pkg::SIZE_SAT) ? 4'(jbec_pkg::SIZE_SAT) : 4'(size);

		len_sat = (len_s1 > jbec_pkg::LEN_MAX) ? jbec_pkg::LEN_MAX : len_s1;
		for (int i = 0; i < jbec_pkg::CODE_W; i++) begin
			code_m[i] = code_s1[i] && (i < int'(len_sat));
		end
	end

	// hand the job to the queue
	always_comb begin
		push       = s1_valid_q && !q_stat.full;
		item_stall = s1_valid_q && q_stat.full;

		push_job.kind         = kind_s1;
		push_job.cls          = cls_s1;
		push_job.symbol       = (kind_s1 == jbec_pkg::JOB_LOAD_DC ||
			kind_s1 == jbec_pkg::JOB_LOAD_AC) ? sym_s1 : {run_s1, snib};
		push_job.zrl_cnt      = zrl_s1;
		push_job.extra_bits   = amp[jbec_pkg::EBITS_W-1:0];
		push_job.extra_length = jbec_pkg::ELEN_W'(size);
		push_job.block_end    = bend_s1;
		push_job.entry        = {len_sat, code_m};
	end

endmodule

`default_nettype wire

@@ rtl/core/jbec_queue.sv @@
`default_nettype none

module jbec_queue #(
	parameter int DEPTH = jbec_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire jbec_pkg::job_t  push_job,
	input  wire logic            pop,
	output jbec_pkg::job_t       head,
	output jbec_pkg::q_stat_t    stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	jbec_pkg::job_t   entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// status and head entry
	always_comb begin
		stat.full     = (count_q == CNT_W'(DEPTH));
		stat.nonempty = (count_q != '0);
		head          = entries_q[rd_ptr_q];
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/jbec_back.sv @@
`default_nettype none

module jbec_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire jbec_pkg::job_t    head,
	input  wire jbec_pkg::q_stat_t q_stat,
	output logic                   pop,
	output logic                   word_valid,
	input  wire logic              word_stall,
	output jbec_pkg::word_t        word
);

	logic [jbec_pkg::ENTRY_W-1:0] dc_mem [jbec_pkg::DC_DEPTH];
	logic [jbec_pkg::ENTRY_W-1:0] ac_mem [jbec_pkg::AC_DEPTH];
	logic [jbec_pkg::ENTRY_W-1:0] dc_rdata_q, ac_rdata_q;

	logic [jbec_pkg::ZRL_W-1:0] sub_q;
	logic                       word_valid_q;
	logic                       sel_dc_q, bend_q, last_q;
	logic [jbec_pkg::EBITS_W-1:0] ebits_q;
	logic [jbec_pkg::ELEN_W-1:0]  elen_q;

	logic out_free, is_load, do_zrl, issue, we_dc, we_ac, rd_dc, rd_ac;
	logic [jbec_pkg::DC_AW-1:0] dc_addr;
	logic [jbec_pkg::AC_AW-1:0] ac_addr;

	// sequence the results of the head job
	always_comb begin
		out_free = !word_valid_q || !word_stall;
		is_load  = (head.kind == jbec_pkg::JOB_LOAD_DC) || (head.kind == jbec_pkg::JOB_LOAD_AC);
		do_zrl   = (head.kind == jbec_pkg::JOB_AC) && (sub_q < head.zrl_cnt);
		issue    = q_stat.nonempty && !is_load && out_free;
		we_dc    = q_stat.nonempty && (head.kind == jbec_pkg::JOB_LOAD_DC);
		we_ac    = q_stat.nonempty && (head.kind == jbec_pkg::JOB_LOAD_AC);
		rd_dc    = issue && (head.kind == jbec_pkg::JOB_DC);
		rd_ac    = issue && (head.kind == jbec_pkg::JOB_AC);
		pop      = (q_stat.nonempty && is_load) || (issue && !do_zrl);
		dc_addr  = {head.cls, head.symbol[3:0]};
		ac_addr  = {head.cls, (do_zrl ? jbec_pkg::SYM_ZRL : head.symbol)};
	end

	// code tables
	always_ff @(posedge clk) begin
		if (we_dc) begin
			dc_mem[dc_addr] <= head.entry;
		end
		if (rd_dc) begin
			dc_rdata_q <= dc_mem[dc_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (we_ac) begin
			ac_mem[ac_addr] <= head.entry;
		end
		if (rd_ac) begin
			ac_rdata_q <= ac_mem[ac_addr];
		end
	end

	// output valid and zrl counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_valid_q <= 1'b0;
			sub_q        <= '0;
		end else begin
			if (out_free) begin
				word_valid_q <= issue;
			end
			if (issue) begin
				sub_q <= do_zrl ? (sub_q + 1'b1) : '0;
			end
		end
	end

	// output side fields
	always_ff @(posedge clk) begin
		if (issue) begin
			sel_dc_q <= (head.kind == jbec_pkg::JOB_DC);
			ebits_q  <= do_zrl ? '0 : head.extra_bits;
			elen_q   <= do_zrl ? '0 : head.extra_length;
			bend_q   <= !do_zrl && head.block_end;
			last_q   <= !do_zrl;
		end
	end

	// result transfer
	always_comb begin
		word_valid        = word_valid_q;
		word.huff_code    = sel_dc_q ? dc_rdata_q[jbec_pkg::CODE_W-1:0] :
			ac_rdata_q[jbec_pkg::CODE_W-1:0];
		word.huff_length  = sel_dc_q ? dc_rdata_q[jbec_pkg::ENTRY_W-1:jbec_pkg::CODE_W] :
			ac_rdata_q[jbec_pkg::ENTRY_W-1:jbec_pkg::CODE_W];
		word.extra_bits   = ebits_q;
		word.extra_length = elen_q;
		word.block_end    = bend_q;
		word.last         = last_q;
	end

endmodule

`default_nettype wire

@@ rtl/core/jpeg_block_entropy_coder_top.sv @@
// Baseline Huffman entropy coder for 8x8 blocks of quantized coefficients in zigzag order.
// Each item is a coefficient, a code table load or a restart; one item is taken per cycle
// while the four-entry job queue between the classifier and the emitter has room. The
// emitter sends one result per cycle from its DC and AC code tables unless the output
// stalls; a coefficient holds it for one result per symbol that it yields (a DC code,
// up to three ZRLs plus a run/size code, or an EOB), a table load yields no result, and
// zero coefficients in mid block and restarts cost the emitter nothing. The first result
// of an item passes the stage-1 register, the job queue and the table read register. Code
// tables hold nothing useful until loaded; no clearing pass runs after reset.
`default_nettype none

module jpeg_block_entropy_coder_top #(
	parameter int COMPONENTS  = jbec_pkg::COMPONENTS,
	parameter int QUEUE_DEPTH = jbec_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	output logic                 item_stall,
	input  wire jbec_pkg::item_t item,
	output logic                 word_valid,
	input  wire logic            word_stall,
	output jbec_pkg::word_t      word
);

	logic              q_push, q_pop;
	jbec_pkg::job_t    q_in, q_head;
	jbec_pkg::q_stat_t q_stat;

	// classifier and state keeper
	jbec_front #(
		.COMPONENTS(COMPONENTS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.push       (q_push),
		.push_job   (q_in),
		.q_stat     (q_stat)
	);

	// job queue
	jbec_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_in),
		.pop      (q_pop),
		.head     (q_head),
		.stat     (q_stat)
	);

	// symbol emitter with code tables
	jbec_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.q_stat     (q_stat),
		.pop        (q_pop),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.word       (word)
	);

`ifndef NO_ASSERTIONS
	// queue never written while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("job queue overflow");

	// queue never read while empty
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_stat.nonempty)
		else $error("job queue underflow");

	// block end only on the closing result of an item
	a_bend_last: assert property (@(posedge clk) disable iff (!arst_n)
		(word_valid && word.block_end) |-> word.last)
		else $error("block end without last");

	// leading ZRL results carry no amplitude bits
	a_zrl_plain: assert property (@(posedge clk) disable iff (!arst_n)
		(word_valid && !word.last) |-> (word.extra_length == '0 && word.extra_bits == '0))
		else $error("amplitude on a leading result");
`endif

endmodule

`default_nettype wire
